// ===== sv/drqc_pkg.sv =====
// shared types and codes for the dedup request queue with cooldown
// no dependencies; used by drqc_ctrl, drqc_dpath and the top level
package drqc_pkg;

  // action codes of an input transaction
  localparam logic [2:0] ACT_REQ   = 3'd0;
  localparam logic [2:0] ACT_TAKE  = 3'd1;
  localparam logic [2:0] ACT_FIN   = 3'd2;
  localparam logic [2:0] ACT_QUERY = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_COOL  = 3'd1;
  localparam logic [2:0] ST_DUP   = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_COOLDOWN = 2'd0;
  localparam logic [1:0] CFG_LIMIT    = 2'd1;

  localparam int MAC_W   = 48;
  localparam int KIND_W  = 8;
  localparam int TIME_W  = 32;

  // commands from controller to datapath
  typedef struct packed {
    logic       cap;         // capture input transaction, reset scan state
    logic       c_inc;       // next cooldown entry
    logic       c_kill;      // invalidate current cooldown entry
    logic       c_track;     // update free slot / oldest stamp tracking
    logic       c_stamp_hit; // refresh stamp of current entry
    logic       c_stamp_pick;// write address and stamp to chosen slot
    logic       c_clear;     // invalidate whole cooldown table
    logic       q_inc;       // next queue slot
    logic       q_head;      // point queue scan at head
    logic       q_push;      // append request at tail
    logic       q_pop;       // remove head, keep its payload
    logic       done_inc;    // count a completion
    logic       set_res;     // latch status and cooling
    logic [2:0] res_status;
    logic       res_cool;
    logic       res_load;    // move staged result to output register
  } drqc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [2:0] act;
    logic       ok;
    logic       cool_hit;
    logic       cool_young;
    logic       cool_last;
    logic       q_hit;
    logic       q_last;
    logic       full;
    logic       empty;
    logic       out_free;
  } drqc_stat_t;

endpackage

// ===== sv/dedup_request_queue_with_cooldown.sv =====
// top level of the dedup request queue with cooldown table
// depends on drqc_pkg, drqc_ctrl and drqc_dpath
//
//  channel | signals                         | direction
//  in      | in_valid/in_ready + item fields | into block
//  out     | out_valid/out_ready + results   | out of block
//  cfg     | cfg_valid/cfg_ready, index/data | into block
//
// request, query and a finish with ok scan the cooldown memory entry by entry
// through its one read port; a request then scans the queue memory the same way.
// reset clears valid bits, pointers and counters at once, no clearing pass.
// a new transaction is taken while the previous result waits in the output
// register; a stalled output holds the block in its final state.
module dedup_request_queue_with_cooldown #(
  parameter int QUEUE_DEPTH  = 8,
  parameter int COOL_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [47:0] mac,
  input  logic [7:0]  addr_kind,
  input  logic        finished_ok,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [47:0] out_mac,
  output logic [7:0]  out_addr_kind,
  output logic        cooling,
  output logic [3:0]  pending,
  output logic [31:0] completed
);
  import drqc_pkg::*;

  drqc_cmd_t  cmd;
  drqc_stat_t stat;

  // config writes always taken
  assign cfg_ready = 1'b1;

  drqc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  drqc_dpath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .COOL_ENTRIES (COOL_ENTRIES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .mac           (mac),
    .addr_kind     (addr_kind),
    .finished_ok   (finished_ok),
    .now_ms        (now_ms),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .status        (status),
    .out_mac       (out_mac),
    .out_addr_kind (out_addr_kind),
    .cooling       (cooling),
    .pending       (pending),
    .completed     (completed)
  );

endmodule

// ===== sv/drqc_dpath.sv =====
// datapath: config registers, ring queue, cooldown table and result register
// depends on drqc_pkg
module drqc_dpath #(
  parameter int QUEUE_DEPTH  = 8,
  parameter int COOL_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  drqc_pkg::drqc_cmd_t  cmd,
  output drqc_pkg::drqc_stat_t stat,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [2:0]           action,
  input  logic [47:0]          mac,
  input  logic [7:0]           addr_kind,
  input  logic                 finished_ok,
  input  logic [31:0]          now_ms,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [2:0]           status,
  output logic [47:0]          out_mac,
  output logic [7:0]           out_addr_kind,
  output logic                 cooling,
  output logic [3:0]           pending,
  output logic [31:0]          completed
);
  import drqc_pkg::*;

  localparam int IW = $clog2(COOL_ENTRIES);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = (CW > 4) ? CW : 4;
  localparam int CE_W = MAC_W + TIME_W;
  localparam int QE_W = MAC_W + KIND_W;

  // config registers
  logic [31:0] cooldown_time;
  logic [3:0]  queue_limit;

  // captured transaction
  logic [2:0]  act_q;
  logic [47:0] mac_q;
  logic [7:0]  kind_q;
  logic        ok_q;
  logic [31:0] now_q;

  // cooldown table
  logic [CE_W-1:0]   cool_mem [COOL_ENTRIES];
  logic [CE_W-1:0]   cool_rd;
  logic [COOL_ENTRIES-1:0] cool_live;
  logic [IW-1:0]     cidx;
  logic              free_found;
  logic [IW-1:0]     free_idx;
  logic [IW-1:0]     min_idx;
  logic [31:0]       min_stamp;
  logic [IW-1:0]     pick;
  logic [31:0]       rd_stamp;
  logic [31:0]       age;

  // ring queue
  logic [QE_W-1:0]   q_mem [QUEUE_DEPTH];
  logic [QE_W-1:0]   q_rd;
  logic [QUEUE_DEPTH-1:0] q_live;
  logic [QW-1:0]     qidx;
  logic [QW-1:0]     head;
  logic [QW-1:0]     tail;
  logic [CW-1:0]     count;
  logic [LW-1:0]     limit;
  logic [LW-1:0]     limit_raw;

  logic [31:0]       done_count;

  // staged result
  logic [2:0]  stage_status;
  logic        stage_cool;
  logic [47:0] stage_mac;
  logic [7:0]  stage_kind;

  // config write port
  always_ff @(posedge clk) begin
    if (rst) begin
      cooldown_time <= 32'd30000;
      queue_limit   <= 4'd8;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COOLDOWN: cooldown_time <= cfg_data;
        CFG_LIMIT:    queue_limit   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // capture of the input transaction
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      act_q  <= action;
      mac_q  <= mac;
      kind_q <= addr_kind;
      ok_q   <= finished_ok;
      now_q  <= now_ms;
    end
  end

  // cooldown entry checks
  assign rd_stamp = cool_rd[TIME_W-1:0];
  assign age      = now_q - rd_stamp;
  assign pick     = free_found ? free_idx : min_idx;

  // cooldown memory, one read and one write port
  always_ff @(posedge clk) begin
    cool_rd <= cool_mem[cidx];
    if (cmd.c_stamp_hit) begin
      cool_mem[cidx] <= {mac_q, now_q};
    end else if (cmd.c_stamp_pick) begin
      cool_mem[pick] <= {mac_q, now_q};
    end
  end

  // cooldown valid bits, scan index and slot choice
  always_ff @(posedge clk) begin
    if (rst) begin
      cool_live  <= '0;
      cidx       <= '0;
      free_found <= 1'b0;
    end else begin
      if (cmd.cap) begin
        cidx       <= '0;
        free_found <= 1'b0;
      end else if (cmd.c_inc) begin
        cidx <= cidx + 1'b1;
      end
      if (cmd.c_track) begin
        if (!cool_live[cidx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= cidx;
        end
        if (cool_live[cidx] && (cidx == '0 || rd_stamp < min_stamp)) begin
          min_idx   <= cidx;
          min_stamp <= rd_stamp;
        end
      end
      if (cmd.c_clear) begin
        cool_live <= '0;
      end else if (cmd.c_kill) begin
        cool_live[cidx] <= 1'b0;
      end else if (cmd.c_stamp_pick) begin
        cool_live[pick] <= 1'b1;
      end
    end
  end

  // queue memory, read at the scan index, written at the tail
  always_ff @(posedge clk) begin
    q_rd <= q_mem[qidx];
    if (cmd.q_push) begin
      q_mem[tail] <= {mac_q, kind_q};
    end
  end

  // queue control and completion counter
  always_ff @(posedge clk) begin
    if (rst) begin
      q_live     <= '0;
      qidx       <= '0;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      done_count <= '0;
    end else begin
      if (cmd.cap) begin
        qidx <= '0;
      end else if (cmd.q_head) begin
        qidx <= head;
      end else if (cmd.q_inc) begin
        qidx <= qidx + 1'b1;
      end
      if (cmd.q_push) begin
        q_live[tail] <= 1'b1;
        tail  <= (tail == QW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
        count <= count + 1'b1;
      end else if (cmd.q_pop) begin
        q_live[head] <= 1'b0;
        head  <= (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end
      if (cmd.done_inc) begin
        done_count <= done_count + 1'b1;
      end
    end
  end

  // effective limit, capped at queue depth
  assign limit_raw = LW'(queue_limit);
  assign limit     = (limit_raw > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH) : limit_raw;

  // status toward the controller
  always_comb begin
    stat.act        = act_q;
    stat.ok         = ok_q;
    stat.cool_hit   = cool_live[cidx] && (cool_rd[CE_W-1:TIME_W] == mac_q);
    stat.cool_young = age < cooldown_time;
    stat.cool_last  = (cidx == IW'(COOL_ENTRIES - 1));
    stat.q_hit      = q_live[qidx] && (q_rd[QE_W-1:KIND_W] == mac_q);
    stat.q_last     = (qidx == QW'(QUEUE_DEPTH - 1));
    stat.full       = LW'(count) >= limit;
    stat.empty      = (count == '0);
    stat.out_free   = !out_valid || out_ready;
  end

  // staged result fields
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      stage_mac  <= '0;
      stage_kind <= '0;
    end else if (cmd.q_pop) begin
      stage_mac  <= q_rd[QE_W-1:KIND_W];
      stage_kind <= q_rd[KIND_W-1:0];
    end
    if (cmd.set_res) begin
      stage_status <= cmd.res_status;
      stage_cool   <= cmd.res_cool;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status        <= stage_status;
      out_mac       <= stage_mac;
      out_addr_kind <= stage_kind;
      cooling       <= stage_cool;
      pending       <= 4'(count);
      completed     <= done_count;
    end
  end

endmodule

// ===== sv/drqc_ctrl.sv =====
// controller state machine sequencing table scans and queue updates
// depends on drqc_pkg
module drqc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  drqc_pkg::drqc_stat_t stat,
  output drqc_pkg::drqc_cmd_t  cmd
);
  import drqc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_C_RD = 4'd2;
  localparam logic [3:0] S_C_CK = 4'd3;
  localparam logic [3:0] S_PICK = 4'd4;
  localparam logic [3:0] S_Q_RD = 4'd5;
  localparam logic [3:0] S_Q_CK = 4'd6;
  localparam logic [3:0] S_T_RD = 4'd7;
  localparam logic [3:0] S_T_CK = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.act) inside
          ACT_REQ, ACT_QUERY: state_next = S_C_RD;
          ACT_TAKE: begin
            if (stat.empty) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_EMPTY;
              state_next     = S_FIN;
            end else begin
              cmd.q_head = 1'b1;
              state_next = S_T_RD;
            end
          end
          ACT_FIN: begin
            cmd.done_inc   = 1'b1;
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_OK;
            state_next     = stat.ok ? S_C_RD : S_FIN;
          end
          ACT_CLEAR: begin
            cmd.c_clear    = 1'b1;
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_OK;
            state_next     = S_FIN;
          end
          default: begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_OK;
            state_next     = S_FIN;
          end
        endcase
      end
      S_C_RD: state_next = S_C_CK;
      S_C_CK: begin
        if (stat.act == ACT_FIN) begin
          // stamping: refresh a match, else remember free and oldest slots
          if (stat.cool_hit) begin
            cmd.c_stamp_hit = 1'b1;
            state_next      = S_FIN;
          end else begin
            cmd.c_track = 1'b1;
            if (stat.cool_last) begin
              state_next = S_PICK;
            end else begin
              cmd.c_inc  = 1'b1;
              state_next = S_C_RD;
            end
          end
        end else if (stat.cool_hit && stat.cool_young) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = (stat.act == ACT_REQ) ? ST_COOL : ST_OK;
          cmd.res_cool   = (stat.act == ACT_QUERY);
          state_next     = S_FIN;
        end else if (stat.cool_hit || stat.cool_last) begin
          // expired entry is dropped; address is free to go on
          cmd.c_kill = stat.cool_hit;
          if (stat.act == ACT_REQ) begin
            state_next = S_Q_RD;
          end else begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_OK;
            state_next     = S_FIN;
          end
        end else begin
          cmd.c_inc  = 1'b1;
          state_next = S_C_RD;
        end
      end
      S_PICK: begin
        cmd.c_stamp_pick = 1'b1;
        state_next       = S_FIN;
      end
      S_Q_RD: state_next = S_Q_CK;
      S_Q_CK: begin
        if (stat.q_hit) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_DUP;
          state_next     = S_FIN;
        end else if (stat.q_last) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = stat.full ? ST_FULL : ST_OK;
          cmd.q_push     = !stat.full;
          state_next     = S_FIN;
        end else begin
          cmd.q_inc  = 1'b1;
          state_next = S_Q_RD;
        end
      end
      S_T_RD: state_next = S_T_CK;
      S_T_CK: begin
        cmd.q_pop      = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_OK;
        state_next     = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== sv/drqc_checker.sv =====
// port-level checks for the dedup request queue with cooldown
// depends on drqc_pkg; bound to the top level below
module drqc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [47:0] out_mac,
  input logic        cooling
);
  import drqc_pkg::*;

  // a waiting result holds until its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped or changed while stalled");

  // status code stays within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_EMPTY)
    else $error("undefined status code");

  // empty take gives a zero address
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> out_mac == '0)
    else $error("empty take with nonzero address");

  // query answer only comes with an ok status
  a_cool_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && cooling |-> status == ST_OK && out_mac == '0)
    else $error("cooling flag with bad status");

  // a new transaction is never taken the cycle after one was taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("back to back transactions taken");

endmodule

bind dedup_request_queue_with_cooldown drqc_checker u_drqc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .out_mac   (out_mac),
  .cooling   (cooling)
);
